// ===== hw/rtl/integer_to_roman_numeral_defines.svh =====
// Assertion macros used by the RTL sequencer
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define INT2ROM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("int2rom: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define INT2ROM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("int2rom: next-cycle check failed");

`endif

// ===== hw/rtl/int2rom_pkg.sv =====
package int2rom_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned WGT_W   = 10;
  localparam int unsigned PC_W    = 5;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
  localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;
  localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYM_W-1:0] SYM_I    = 8'h49;

  // Program step addresses
  localparam logic [PC_W-1:0] PC_M      = 5'd0;
  localparam logic [PC_W-1:0] PC_CM_A   = 5'd1;
  localparam logic [PC_W-1:0] PC_CM_B   = 5'd2;
  localparam logic [PC_W-1:0] PC_D      = 5'd3;
  localparam logic [PC_W-1:0] PC_C      = 5'd4;
  localparam logic [PC_W-1:0] PC_CD_A   = 5'd5;
  localparam logic [PC_W-1:0] PC_CD_B   = 5'd6;
  localparam logic [PC_W-1:0] PC_XC_A   = 5'd7;
  localparam logic [PC_W-1:0] PC_XC_B   = 5'd8;
  localparam logic [PC_W-1:0] PC_L      = 5'd9;
  localparam logic [PC_W-1:0] PC_X      = 5'd10;
  localparam logic [PC_W-1:0] PC_XL_A   = 5'd11;
  localparam logic [PC_W-1:0] PC_XL_B   = 5'd12;
  localparam logic [PC_W-1:0] PC_IX_A   = 5'd13;
  localparam logic [PC_W-1:0] PC_IX_B   = 5'd14;
  localparam logic [PC_W-1:0] PC_V      = 5'd15;
  localparam logic [PC_W-1:0] PC_I      = 5'd16;
  localparam logic [PC_W-1:0] PC_IV_A   = 5'd17;
  localparam logic [PC_W-1:0] PC_IV_B   = 5'd18;

  // One control word: test against tst, on pass emit sym, subtract sub, go to jp; on fail go to jf
  typedef struct packed {
    logic [WGT_W-1:0] tst;
    logic [WGT_W-1:0] sub;
    logic [SYM_W-1:0] sym;
    logic [PC_W-1:0]  jp;
    logic [PC_W-1:0]  jf;
  } ucode_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             error;
  } emit_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_M:    w = '{tst: 10'd1000, sub: 10'd1000, sym: SYM_M, jp: PC_M,    jf: PC_CM_A};
      PC_CM_A: w = '{tst: 10'd900,  sub: 10'd0,    sym: SYM_C, jp: PC_CM_B, jf: PC_D};
      PC_CM_B: w = '{tst: 10'd0,    sub: 10'd900,  sym: SYM_M, jp: PC_XC_A, jf: PC_XC_A};
      PC_D:    w = '{tst: 10'd500,  sub: 10'd500,  sym: SYM_D, jp: PC_C,    jf: PC_CD_A};
      PC_C:    w = '{tst: 10'd100,  sub: 10'd100,  sym: SYM_C, jp: PC_C,    jf: PC_XC_A};
      PC_CD_A: w = '{tst: 10'd400,  sub: 10'd0,    sym: SYM_C, jp: PC_CD_B, jf: PC_C};
      PC_CD_B: w = '{tst: 10'd0,    sub: 10'd400,  sym: SYM_D, jp: PC_XC_A, jf: PC_XC_A};
      PC_XC_A: w = '{tst: 10'd90,   sub: 10'd0,    sym: SYM_X, jp: PC_XC_B, jf: PC_L};
      PC_XC_B: w = '{tst: 10'd0,    sub: 10'd90,   sym: SYM_C, jp: PC_IX_A, jf: PC_IX_A};
      PC_L:    w = '{tst: 10'd50,   sub: 10'd50,   sym: SYM_L, jp: PC_X,    jf: PC_XL_A};
      PC_X:    w = '{tst: 10'd10,   sub: 10'd10,   sym: SYM_X, jp: PC_X,    jf: PC_IX_A};
      PC_XL_A: w = '{tst: 10'd40,   sub: 10'd0,    sym: SYM_X, jp: PC_XL_B, jf: PC_X};
      PC_XL_B: w = '{tst: 10'd0,    sub: 10'd40,   sym: SYM_L, jp: PC_IX_A, jf: PC_IX_A};
      PC_IX_A: w = '{tst: 10'd9,    sub: 10'd0,    sym: SYM_I, jp: PC_IX_B, jf: PC_V};
      PC_IX_B: w = '{tst: 10'd0,    sub: 10'd9,    sym: SYM_X, jp: PC_M,    jf: PC_M};
      PC_V:    w = '{tst: 10'd5,    sub: 10'd5,    sym: SYM_V, jp: PC_I,    jf: PC_IV_A};
      PC_I:    w = '{tst: 10'd1,    sub: 10'd1,    sym: SYM_I, jp: PC_I,    jf: PC_M};
      PC_IV_A: w = '{tst: 10'd4,    sub: 10'd0,    sym: SYM_I, jp: PC_IV_B, jf: PC_I};
      PC_IV_B: w = '{tst: 10'd0,    sub: 10'd4,    sym: SYM_V, jp: PC_M,    jf: PC_M};
      default: w = '{tst: 10'd1023, sub: 10'd0,    sym: SYM_NONE, jp: PC_M, jf: PC_M};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/int2rom_seq.sv =====
`include "integer_to_roman_numeral_defines.svh"

module int2rom_seq
  import int2rom_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  input  logic               adv,
  output logic               busy,
  output emit_t              emit
);

  logic               busy_r, busy_nxt;
  logic               err_r, err_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;

  ucode_t             uw;
  logic               pass;
  logic [VALUE_W-1:0] rem_sub;
  logic               step;

  always_comb begin
    uw      = ucode_rom(pc_r);
    pass    = rem_r >= {2'b00, uw.tst};
    rem_sub = rem_r - {2'b00, uw.sub};

    emit.valid  = busy_r && (err_r || pass);
    emit.symbol = err_r ? SYM_NONE : uw.sym;
    emit.last   = err_r || (rem_sub == '0);
    emit.error  = err_r;

    step = busy_r && (!emit.valid || adv);

    busy_nxt = busy_r;
    err_nxt  = err_r;
    pc_nxt   = pc_r;
    rem_nxt  = rem_r;

    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        err_nxt  = (value == '0) || (value > VALUE_MAX);
        pc_nxt   = PC_M;
        rem_nxt  = value;
      end
    end else if (step) begin
      if (err_r) begin
        busy_nxt = 1'b0;
      end else if (pass) begin
        rem_nxt = rem_sub;
        pc_nxt  = uw.jp;
        if (rem_sub == '0) begin
          busy_nxt = 1'b0;
        end
      end else begin
        pc_nxt = uw.jf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      pc_r   <= PC_M;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      pc_r   <= pc_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;

  `INT2ROM_ASSERT_NOW(a_err_is_last, emit.valid && emit.error, emit.last && emit.symbol == SYM_NONE)
  `INT2ROM_ASSERT_NEXT(a_last_ends_run, emit.valid && emit.last && adv, !busy_r)
  `INT2ROM_ASSERT_NOW(a_err_range, busy_r && err_r, rem_r == '0 || rem_r > VALUE_MAX)
  `INT2ROM_ASSERT_NOW(a_pc_in_program, busy_r && !err_r, pc_r <= PC_IV_B && rem_r != '0)

endmodule

// ===== hw/rtl/integer_to_roman_numeral.sv =====
// An accepted input value is loaded into the sequencer, which runs the table tests in order;
// every failed test ahead of the first character delays it, and each character is registered.
// Throughput: one step per cycle while the output register is not stalled; each character and
// each failed test is a step. Busy stalls the input until the last step of a value is taken.
// An out-of-range value gives a single error result.
// Reset (rst_n low, synchronous) idles the sequencer and empties the output register.
module integer_to_roman_numeral
  import int2rom_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SYM_W-1:0]   out_symbol,
  output logic               out_last,
  output logic               out_error
);

  logic             busy;
  logic             adv;
  emit_t            emit;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_symbol_r;
  logic             out_last_r;
  logic             out_error_r;

  assign in_stall = busy;
  assign adv      = !out_valid_r || !out_stall;

  int2rom_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid),
    .value (in_value),
    .adv   (adv),
    .busy  (busy),
    .emit  (emit)
  );

  // hold the result while the transfer is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit.valid;
    end
    if (adv && emit.valid) begin
      out_symbol_r <= emit.symbol;
      out_last_r   <= emit.last;
      out_error_r  <= emit.error;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule

// ===== tb/sv/roman_checker.sv =====
`timescale 1ns / 1ps

module roman_checker
  import int2rom_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [SYM_W-1:0]   out_symbol,
  input  logic               out_last,
  input  logic               out_error,
  output int                 pending,
  output int                 mismatches
);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             error;
  } roman_char_t;

  roman_char_t expected_chars[$];

  function automatic void queue_numeral(input logic [VALUE_W-1:0] v);
    logic [SYM_W-1:0] one [4];
    logic [SYM_W-1:0] five [4];
    logic [SYM_W-1:0] ten [4];
    int unsigned      weight [4];
    logic [SYM_W-1:0] run[$];
    int unsigned      rem;
    int unsigned      d;
    roman_char_t      c;
    one    = '{SYM_M, SYM_C, SYM_X, SYM_I};
    five   = '{SYM_NONE, SYM_D, SYM_L, SYM_V};
    ten    = '{SYM_NONE, SYM_M, SYM_C, SYM_X};
    weight = '{1000, 100, 10, 1};
    if (v == '0 || v > VALUE_MAX) begin
      c = '{symbol: SYM_NONE, last: 1'b1, error: 1'b1};
      expected_chars.push_back(c);
      return;
    end
    rem = 32'(v);
    for (int p = 0; p < 4; p++) begin
      d = rem / weight[p];
      rem = rem - d * weight[p];
      if (d >= 1 && d <= 3) begin
        for (int i = 0; i < d; i++) run.push_back(one[p]);
      end else if (d == 4) begin
        run.push_back(one[p]);
        run.push_back(five[p]);
      end else if (d >= 5 && d <= 8) begin
        run.push_back(five[p]);
        for (int i = 5; i < d; i++) run.push_back(one[p]);
      end else if (d == 9) begin
        run.push_back(one[p]);
        run.push_back(ten[p]);
      end
    end
    for (int k = 0; k < run.size(); k++) begin
      c = '{symbol: run[k], last: (k == run.size() - 1), error: 1'b0};
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin : watch
    roman_char_t want;
    roman_char_t got;
    if (!rst_n) begin
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{symbol: out_symbol, last: out_last, error: out_error};
        if (expected_chars.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transfer: sym=%h last=%b err=%b",
                     got.symbol, got.last, got.error);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("mismatch: want sym=%h last=%b err=%b, got sym=%h last=%b err=%b",
                       want.symbol, want.last, want.error,
                       got.symbol, got.last, got.error);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) queue_numeral(in_value);
    end
    pending = expected_chars.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import int2rom_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [SYM_W-1:0]   out_symbol;
  logic               out_last;
  logic               out_error;
  int                 pending;
  int                 mismatches;
  int                 cycles;
  bit                 quiet;

  integer_to_roman_numeral uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .out_error (out_error)
  );

  roman_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .out_error (out_error),
    .pending   (pending),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("integer_to_roman_numeral test failed");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_value <= VALUE_W'($urandom_range(0, 4095));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return VALUE_W'($urandom_range(4000, 4095));
    if (sel < 5) return VALUE_W'($urandom_range(1, 99));
    return VALUE_W'($urandom_range(1, 3999));
  endfunction

  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 8);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] directed[$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    quiet    = 1'b0;
    directed = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd8, 12'd1994,
                 12'd2048, 12'd1000, 12'd3000, 12'd444, 12'd999, 12'd14, 12'd3,
                 12'd2730, 12'd1365, 12'd10};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_value(directed[i]);
    drain();

    for (int n = 0; n < 95; n++) begin
      if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == 60) drain();
      send_value(pick_value());
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("integer_to_roman_numeral test passed");
    end else begin
      $display("integer_to_roman_numeral test failed");
    end
    $finish;
  end

endmodule
